// ----- rtl/ir_pulse_width_frame_decoder_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the IR pulse-width frame decoder.
// Each macro expects signals named clk and rst in the scope of its use.
// ---------------------------------------------------------------------------
`ifndef IR_PULSE_WIDTH_FRAME_DECODER_ASSERT_SVH
`define IR_PULSE_WIDTH_FRAME_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPWFD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define IPWFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/ipwfd_pkg.sv -----
// ---------------------------------------------------------------------------
// ipwfd_pkg
// Shared constants, types and helpers of the IR pulse-width frame decoder.
// ---------------------------------------------------------------------------
package ipwfd_pkg;

  localparam int unsigned FRAME_BITS_DEFAULT = 16;
  localparam int unsigned WORD_W             = 16;
  localparam int unsigned WIDTH_W            = 8;
  localparam int unsigned OWN_TEAM_W         = 4;
  localparam int unsigned PLAYER_W           = 4;
  localparam int unsigned TEAM_W             = 3;
  localparam int unsigned CFG_INDEX_W        = 3;
  localparam int unsigned CFG_DATA_W         = 8;
  localparam int unsigned QUEUE_DEPTH        = 2;

  localparam int unsigned PLAYER_LSB = 11;
  localparam int unsigned TEAM_LSB   = 8;
  localparam int unsigned BYTE_W     = 8;

  localparam logic [WIDTH_W-1:0]    WIN_MIN_RESET  = 8'd0;
  localparam logic [WIDTH_W-1:0]    WIN_MAX_RESET  = 8'd255;
  localparam logic [OWN_TEAM_W-1:0] OWN_TEAM_RESET = 4'd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_MIN = 3'd0,
    REG_START_MAX = 3'd1,
    REG_ZERO_MIN  = 3'd2,
    REG_ZERO_MAX  = 3'd3,
    REG_ONE_MIN   = 3'd4,
    REG_ONE_MAX   = 3'd5,
    REG_OWN_TEAM  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic timeout;
    logic start_hit;
    logic data_hit;
    logic data_bit;
  } cls_t;

  typedef struct packed {
    logic active;
    logic emit;
  } back_status_t;

  function automatic logic in_window(input logic [WIDTH_W-1:0] w,
                                     input logic [WIDTH_W-1:0] lo,
                                     input logic [WIDTH_W-1:0] hi);
    return (w > lo) && (w < hi);
  endfunction

endpackage

// ----- rtl/ipwfd_if.sv -----
// ---------------------------------------------------------------------------
// ipwfd interfaces
// Valid/ready channels for pulse events, decoded frames and register writes.
// ---------------------------------------------------------------------------
interface ipwfd_pulse_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic [ipwfd_pkg::WIDTH_W-1:0]      pulse_width;

  modport source (output valid, action, pulse_width, input ready);
  modport sink   (input valid, action, pulse_width, output ready);
endinterface

interface ipwfd_result_if;
  logic                               valid;
  logic                               ready;
  logic [ipwfd_pkg::WORD_W-1:0]       frame_word;
  logic [ipwfd_pkg::PLAYER_W-1:0]     player_id;
  logic [ipwfd_pkg::TEAM_W-1:0]       team_id;
  logic                               copy_ok;
  logic                               foreign_hit;

  modport source (output valid, frame_word, player_id, team_id, copy_ok, foreign_hit,
                  input ready);
  modport sink   (input valid, frame_word, player_id, team_id, copy_ok, foreign_hit,
                  output ready);
endinterface

interface ipwfd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ipwfd_pkg::CFG_INDEX_W-1:0]  index;
  logic [ipwfd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/ipwfd_front.sv -----
// ---------------------------------------------------------------------------
// ipwfd_front
// Holds the window registers and classifies each accepted pulse event.
// ---------------------------------------------------------------------------
module ipwfd_front (
  input  logic                                 clk,
  input  logic                                 rst,
  ipwfd_pulse_if.sink                          pulse,
  ipwfd_cfg_if.sink                            cfg,
  input  logic                                 q_full,
  output logic                                 q_push,
  output ipwfd_pkg::cls_t                      q_data,
  output logic [ipwfd_pkg::OWN_TEAM_W-1:0]     own_team
);

  logic [ipwfd_pkg::WIDTH_W-1:0] start_lo;
  logic [ipwfd_pkg::WIDTH_W-1:0] start_hi;
  logic [ipwfd_pkg::WIDTH_W-1:0] zero_min;
  logic [ipwfd_pkg::WIDTH_W-1:0] zero_max;
  logic [ipwfd_pkg::WIDTH_W-1:0] one_min;
  logic [ipwfd_pkg::WIDTH_W-1:0] one_max;
  logic                          zero_match;
  logic                          one_match;
  logic                          start_match;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_lo  <= ipwfd_pkg::WIN_MIN_RESET;
      start_hi  <= ipwfd_pkg::WIN_MAX_RESET;
      zero_min  <= ipwfd_pkg::WIN_MIN_RESET;
      zero_max  <= ipwfd_pkg::WIN_MAX_RESET;
      one_min   <= ipwfd_pkg::WIN_MIN_RESET;
      one_max   <= ipwfd_pkg::WIN_MAX_RESET;
      own_team  <= ipwfd_pkg::OWN_TEAM_RESET;
    end else if (cfg.valid) begin
      unique case (ipwfd_pkg::cfg_reg_t'(cfg.index))
        ipwfd_pkg::REG_START_MIN: start_lo  <= cfg.data;
        ipwfd_pkg::REG_START_MAX: start_hi  <= cfg.data;
        ipwfd_pkg::REG_ZERO_MIN:  zero_min  <= cfg.data;
        ipwfd_pkg::REG_ZERO_MAX:  zero_max  <= cfg.data;
        ipwfd_pkg::REG_ONE_MIN:   one_min   <= cfg.data;
        ipwfd_pkg::REG_ONE_MAX:   one_max   <= cfg.data;
        ipwfd_pkg::REG_OWN_TEAM:  own_team  <= cfg.data[ipwfd_pkg::OWN_TEAM_W-1:0];
        default: ;
      endcase
    end
  end

  assign start_match = ipwfd_pkg::in_window(pulse.pulse_width, start_lo, start_hi);
  assign zero_match  = ipwfd_pkg::in_window(pulse.pulse_width, zero_min, zero_max);
  assign one_match   = ipwfd_pkg::in_window(pulse.pulse_width, one_min, one_max);

  assign pulse.ready = !q_full;
  assign q_push      = pulse.valid && !q_full;

  // The zero window takes precedence over the one window.
  always_comb begin
    q_data.timeout   = pulse.action;
    q_data.start_hit = !pulse.action && start_match;
    q_data.data_hit  = !pulse.action && (zero_match || one_match);
    q_data.data_bit  = !zero_match && one_match;
  end

endmodule

// ----- rtl/ipwfd_queue.sv -----
// ---------------------------------------------------------------------------
// ipwfd_queue
// Short FIFO of classified events between the front and the back.
// ---------------------------------------------------------------------------
module ipwfd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ipwfd_pkg::cls_t  push_data,
  output logic             full,
  input  logic             pop,
  output ipwfd_pkg::cls_t  pop_data,
  output logic             empty
);

  // The depth is a power of two, so the pointers wrap on their own.
  localparam int unsigned PTR_W = $clog2(ipwfd_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(ipwfd_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(ipwfd_pkg::QUEUE_DEPTH);

  ipwfd_pkg::cls_t   entries [ipwfd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = (count == DEPTH_CNT);
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/ipwfd_back.sv -----
// ---------------------------------------------------------------------------
// ipwfd_back
// Frame state machine: shifts in data bits and registers finished frames.
// ---------------------------------------------------------------------------
module ipwfd_back #(
  parameter int unsigned FRAME_BITS = ipwfd_pkg::FRAME_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 empty,
  input  ipwfd_pkg::cls_t                      head,
  output logic                                 pop,
  input  logic [ipwfd_pkg::OWN_TEAM_W-1:0]     own_team,
  ipwfd_result_if.source                       result,
  output ipwfd_pkg::back_status_t              status
);

  localparam int unsigned CNT_W = $clog2(FRAME_BITS + 2);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_BITS);
  localparam int unsigned W = ipwfd_pkg::WORD_W;
  localparam int unsigned B = ipwfd_pkg::BYTE_W;

  logic [CNT_W-1:0] bit_counter;
  logic [CNT_W-1:0] bit_counter_next;
  logic [W-1:0]     shift_word;
  logic [W-1:0]     shift_word_next;
  logic             emit;
  logic [ipwfd_pkg::TEAM_W-1:0] team_next;
  logic             copy_next;

  assign pop = !empty && (!result.valid || result.ready);

  always_comb begin
    bit_counter_next = bit_counter;
    shift_word_next  = shift_word;
    emit             = 1'b0;
    if (pop) begin
      priority if (head.timeout) begin
        bit_counter_next = '0;
        shift_word_next  = '0;
      end else if (bit_counter == '0) begin
        if (head.start_hit) begin
          bit_counter_next = CNT_W'(1);
          shift_word_next  = '0;
        end
      end else if (head.data_hit) begin
        shift_word_next = {shift_word[W-2:0], head.data_bit};
        if (bit_counter == LAST_CNT) begin
          bit_counter_next = '0;
          emit             = 1'b1;
        end else begin
          bit_counter_next = bit_counter + CNT_W'(1);
        end
      end else begin
        bit_counter_next = bit_counter;
      end
    end
  end

  assign team_next = shift_word_next[ipwfd_pkg::TEAM_LSB +: ipwfd_pkg::TEAM_W];
  assign copy_next = (shift_word_next[W-1:W-B] == shift_word_next[B-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_counter  <= '0;
      shift_word   <= '0;
      result.valid <= 1'b0;
    end else begin
      bit_counter <= bit_counter_next;
      shift_word  <= shift_word_next;
      if (emit) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.frame_word  <= shift_word_next;
      result.player_id   <= shift_word_next[ipwfd_pkg::PLAYER_LSB +: ipwfd_pkg::PLAYER_W];
      result.team_id     <= team_next;
      result.copy_ok     <= copy_next;
      result.foreign_hit <= copy_next && ({1'b0, team_next} != own_team);
    end
  end

  assign status.active = (bit_counter != '0);
  assign status.emit   = emit;

endmodule

// ----- rtl/ir_pulse_width_frame_decoder.sv -----
// ---------------------------------------------------------------------------
// ir_pulse_width_frame_decoder
// Decodes pulse-width infrared frames into player, team and hit flags.
//
// The pulse channel carries one event per transfer: a measured pulse width or
// a timeout. The result channel carries one decoded frame per transfer, sent
// when the last data bit of a frame arrives. The cfg channel writes the six
// window bounds and the own team number; it is always ready and should be
// used only while no events are in flight.
// An event is classified against the windows when it is taken and placed in
// a two-entry queue; the frame engine takes one entry per cycle unless the
// result channel stalls. Each frame result is held in an output register,
// and the block takes one event per cycle while the result channel keeps up.
// When the receiver stalls, the finished frame waits in the output register
// and up to two further events are still taken before pulse.ready drops.
// Reset clears the queue and the frame state and restores the register
// defaults: all windows open, own team zero.
// ---------------------------------------------------------------------------
`include "ir_pulse_width_frame_decoder_assert.svh"

module ir_pulse_width_frame_decoder #(
  parameter int unsigned FRAME_BITS = ipwfd_pkg::FRAME_BITS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  ipwfd_pulse_if.sink     pulse,
  ipwfd_result_if.source  result,
  ipwfd_cfg_if.sink       cfg
);

  logic                                q_push;
  logic                                q_full;
  logic                                q_pop;
  logic                                q_empty;
  ipwfd_pkg::cls_t                     q_in;
  ipwfd_pkg::cls_t                     q_head;
  logic [ipwfd_pkg::OWN_TEAM_W-1:0]    own_team;
  ipwfd_pkg::back_status_t             back_status;

  ipwfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .pulse    (pulse),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in),
    .own_team (own_team)
  );

  ipwfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_head),
    .empty     (q_empty)
  );

  ipwfd_back #(
    .FRAME_BITS (FRAME_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (q_empty),
    .head     (q_head),
    .pop      (q_pop),
    .own_team (own_team),
    .result   (result),
    .status   (back_status)
  );

  `IPWFD_ASSERT_SAME(a_foreign_needs_copy, result.valid, !result.foreign_hit || result.copy_ok)
  `IPWFD_ASSERT_NEXT(a_timeout_clears, q_pop && q_head.timeout, !back_status.active)
  `IPWFD_ASSERT_NEXT(a_emit_shows_result, back_status.emit, result.valid)

endmodule
